>>> rtl/ked_pkg.sv
// ked_pkg: shared types and constants of the key event detector.
// Depends on nothing; used by every module of the block but ked_div.
package ked_pkg;

  // Input beat and result beat
  typedef struct packed {
    logic [2:0]  key_index;
    logic        pin_level;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_key;
    logic [2:0] event_code;
    logic       last_event;
  } out_item_t;

  // Configuration register file
  typedef struct packed {
    logic        active_high;
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] repeat_interval_ms;
    logic        long_press_enable;
    logic        double_click_enable;
    logic        repeat_enable;
    logic [7:0]  key_enable_mask;
  } cfg_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic [2:0]  key;
    logic        pressed;
    logic [31:0] now_ms;
  } work_t;

  localparam logic [2:0] REG_ACTIVE_HIGH  = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd2;
  localparam logic [2:0] REG_REPEAT_IVL   = 3'd3;
  localparam logic [2:0] REG_LONG_EN      = 3'd4;
  localparam logic [2:0] REG_DOUBLE_EN    = 3'd5;
  localparam logic [2:0] REG_REPEAT_EN    = 3'd6;
  localparam logic [2:0] REG_KEY_MASK     = 3'd7;

  localparam logic [1:0] PH_RELEASED = 2'd0;
  localparam logic [1:0] PH_PRESSED  = 2'd1;
  localparam logic [1:0] PH_DEBOUNCE = 2'd2;
  localparam logic [1:0] PH_LONG     = 2'd3;

  localparam logic [2:0] EV_DOWN       = 3'd0;
  localparam logic [2:0] EV_UP         = 3'd1;
  localparam logic [2:0] EV_SHORT      = 3'd2;
  localparam logic [2:0] EV_DOUBLE     = 3'd3;
  localparam logic [2:0] EV_LONG_START = 3'd4;
  localparam logic [2:0] EV_HOLD       = 3'd5;
  localparam logic [2:0] EV_LONG_UP    = 3'd6;
  localparam logic [2:0] EV_REPEAT     = 3'd7;

  localparam logic [31:0] DOUBLE_WINDOW_MS = 32'd500;
  localparam logic [31:0] HOLD_PERIOD_MS   = 32'd200;

endpackage

>>> rtl/ked_front.sv
// ked_front: accepts scan samples, drops disabled or out-of-range keys,
// decodes the pin level and queues the sample for the back end. Uses ked_pkg.
module ked_front #(
  parameter int NUM_KEYS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ked_pkg::cfg_t   cfg,
  input  logic            in_push,
  input  ked_pkg::in_item_t in_item,
  output logic            in_full,
  output logic            wq_valid,
  output ked_pkg::work_t  wq_item,
  input  logic            wq_pop
);
  import ked_pkg::*;

  work_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       acc, keep;
  work_t      w;

  // Classify the sample
  always_comb begin
    acc       = in_push && !in_full;
    keep      = (32'(in_item.key_index) < NUM_KEYS) &&
                cfg.key_enable_mask[in_item.key_index];
    w.key     = in_item.key_index;
    w.pressed = cfg.active_high ? in_item.pin_level : !in_item.pin_level;
    w.now_ms  = in_item.now_ms;
  end

  assign in_full  = (cnt_r == 2'd2);
  assign wq_valid = (cnt_r != 2'd0);
  assign wq_item  = q_r[rp_r];

  // Two-entry queue storage
  always_ff @(posedge clk) begin
    if (acc && keep) q_r[wp_r] <= w;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (acc && keep) wp_r <= !wp_r;
      if (wq_pop && wq_valid) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(acc && keep) - 2'(wq_pop && wq_valid);
    end
  end
endmodule

>>> rtl/ked_div.sv
// ked_div: restoring divider, 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle. Uses nothing from the package.
module ked_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        busy,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] q_r;
  logic [15:0] rem_r, den_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [16:0] r2;
  logic        ge;

  // One restoring step
  always_comb begin
    r2 = {rem_r, q_r[31]};
    ge = (r2 >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= 16'd0;
      den_r <= (den == 16'd0) ? 16'd1 : den;
    end else if (busy_r) begin
      rem_r <= ge ? 16'(r2 - {1'b0, den_r}) : r2[15:0];
      q_r   <= {q_r[30:0], ge};
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;
endmodule

>>> rtl/ked_back.sv
// ked_back: per-key state machines, event generation and the result queue.
// Depends on ked_pkg and ked_div.
module ked_back #(
  parameter int NUM_KEYS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ked_pkg::cfg_t      cfg,
  input  logic               wq_valid,
  input  ked_pkg::work_t     wq_item,
  output logic               wq_pop,
  output logic               out_empty,
  output ked_pkg::out_item_t out_item,
  input  logic               out_pop
);
  import ked_pkg::*;

  localparam int NK = (NUM_KEYS < 8) ? NUM_KEYS : 8;
  localparam int KW = (NK > 1) ? $clog2(NK) : 1;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV} st_t;

  st_t         st_r;
  work_t       cur_r;
  logic        lstart_r;
  logic [1:0]  ph_r [NK];
  logic [31:0] ps_r [NK];
  logic [31:0] rs_r [NK];
  logic [15:0] ct_r [NK];
  logic [31:0] hs_r [NK];

  logic [KW-1:0] idx;
  logic [1:0]    ph;
  logic [31:0]   ps, rs, hs, dur, num;
  logic [15:0]   ct, tnext;

  // Update decision
  logic [1:0]  n_push;
  logic [2:0]  ev0, ev1;
  logic        w_ph, w_ps, w_rs, w_ct, w_hs, need_div, set_lstart;
  logic [1:0]  ph_nxt;
  logic [15:0] ct_nxt;

  logic        div_start, div_busy, div_done;
  logic [31:0] div_quo;

  out_item_t   fq_r [4];
  logic [1:0]  fwp_r, frp_r;
  logic [2:0]  fcnt_r;
  logic        fpop;

  assign idx = cur_r.key[KW-1:0];
  assign ph  = ph_r[idx];
  assign ps  = ps_r[idx];
  assign rs  = rs_r[idx];
  assign ct  = ct_r[idx];
  assign hs  = hs_r[idx];
  assign dur = cur_r.now_ms - ps;
  assign num = dur - {16'd0, cfg.long_press_ms};
  assign tnext = ct + 16'd1;

  assign wq_pop    = (st_r == S_IDLE) && wq_valid && (fcnt_r <= 3'd2);
  assign div_start = (st_r == S_EVAL) && need_div;

  ked_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (cfg.repeat_interval_ms),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Phase machine of the current key
  always_comb begin
    n_push = 2'd0; ev0 = EV_DOWN; ev1 = EV_DOWN;
    w_ph = 1'b0; w_ps = 1'b0; w_rs = 1'b0; w_ct = 1'b0; w_hs = 1'b0;
    ph_nxt = ph; ct_nxt = ct; need_div = 1'b0; set_lstart = 1'b0;
    if (st_r == S_EVAL) begin
      unique case (ph)
        PH_RELEASED: begin
          if (cur_r.pressed) begin
            w_ph = 1'b1; ph_nxt = PH_DEBOUNCE; w_ps = 1'b1;
          end
        end
        PH_DEBOUNCE: begin
          if (!cur_r.pressed) begin
            w_ph = 1'b1; ph_nxt = PH_RELEASED;
          end else if (dur >= {16'd0, cfg.debounce_ms}) begin
            w_ph = 1'b1; ph_nxt = PH_PRESSED;
            n_push = 2'd1; ev0 = EV_DOWN;
            if (cfg.double_click_enable) begin
              w_ct = 1'b1;
              if ((cur_r.now_ms - rs) < DOUBLE_WINDOW_MS) begin
                if (tnext == 16'd2) begin
                  n_push = 2'd2; ev1 = EV_DOUBLE; ct_nxt = 16'd0;
                end else begin
                  ct_nxt = tnext;
                end
              end else begin
                ct_nxt = 16'd1;
              end
            end
          end
        end
        PH_PRESSED: begin
          if (!cur_r.pressed) begin
            w_ph = 1'b1; ph_nxt = PH_DEBOUNCE; w_rs = 1'b1;
            n_push = 2'd2; ev0 = EV_UP;
            ev1 = (dur < {16'd0, cfg.long_press_ms}) ? EV_SHORT : EV_LONG_UP;
          end else begin
            if (cfg.long_press_enable && dur >= {16'd0, cfg.long_press_ms}) begin
              w_ph = 1'b1; ph_nxt = PH_LONG; set_lstart = 1'b1;
            end
            if (cfg.repeat_enable && dur > {16'd0, cfg.long_press_ms}) begin
              need_div = 1'b1;
            end else if (set_lstart) begin
              n_push = 2'd1; ev0 = EV_LONG_START;
            end
          end
        end
        PH_LONG: begin
          if (!cur_r.pressed) begin
            w_ph = 1'b1; ph_nxt = PH_DEBOUNCE; w_rs = 1'b1;
            n_push = 2'd2; ev0 = EV_UP; ev1 = EV_LONG_UP;
          end else if ((cur_r.now_ms - hs) >= HOLD_PERIOD_MS) begin
            n_push = 2'd1; ev0 = EV_HOLD; w_hs = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (st_r == S_DIV && div_done) begin
      // Repeat count known: long start (if any) goes first
      if (div_quo > {16'd0, ct}) begin
        w_ct = 1'b1; ct_nxt = div_quo[15:0];
        if (lstart_r) begin
          n_push = 2'd2; ev0 = EV_LONG_START; ev1 = EV_REPEAT;
        end else begin
          n_push = 2'd1; ev0 = EV_REPEAT;
        end
      end else if (lstart_r) begin
        n_push = 2'd1; ev0 = EV_LONG_START;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      lstart_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (wq_pop) st_r <= S_EVAL;
        S_EVAL: begin
          lstart_r <= set_lstart;
          st_r     <= need_div ? S_DIV : S_IDLE;
        end
        S_DIV:  if (div_done) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wq_pop) cur_r <= wq_item;
  end

  // Per-key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NK; i++) begin
        ph_r[i] <= PH_RELEASED;
        ps_r[i] <= 32'd0;
        rs_r[i] <= 32'd0;
        ct_r[i] <= 16'd0;
        hs_r[i] <= 32'd0;
      end
    end else begin
      if (w_ph) ph_r[idx] <= ph_nxt;
      if (w_ps) ps_r[idx] <= cur_r.now_ms;
      if (w_rs) rs_r[idx] <= cur_r.now_ms;
      if (w_ct) ct_r[idx] <= ct_nxt;
      if (w_hs) hs_r[idx] <= cur_r.now_ms;
    end
  end

  // Result queue, up to two beats written per cycle
  assign fpop      = out_pop && !out_empty;
  assign out_empty = (fcnt_r == 3'd0);
  assign out_item  = fq_r[frp_r];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fq_r[fwp_r] <= '{event_key: cur_r.key, event_code: ev0,
                       last_event: (n_push == 2'd1)};
    end
    if (n_push == 2'd2) begin
      fq_r[fwp_r + 2'd1] <= '{event_key: cur_r.key, event_code: ev1,
                              last_event: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwp_r  <= 2'd0;
      frp_r  <= 2'd0;
      fcnt_r <= 3'd0;
    end else begin
      fwp_r  <= fwp_r + n_push;
      if (fpop) frp_r <= frp_r + 2'd1;
      fcnt_r <= fcnt_r + 3'(n_push) - 3'(fpop);
    end
  end

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= 3'd4) else $error("result queue overflow");
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != 2'd0) |-> (fcnt_r <= 3'd2)) else $error("push without room");
  a_div_live: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (div_busy || div_done)) else $error("divider idle in S_DIV");
  a_one_pop: assert property (@(posedge clk) disable iff (!rst_n)
    wq_pop |=> (st_r == S_EVAL)) else $error("sample popped but not evaluated");
`endif
endmodule

>>> rtl/key_event_detector_unit.sv
// key_event_detector_unit: top level with the configuration registers.
// Depends on ked_pkg, ked_front and ked_back.
//
// Usage:
//   Input queue: a scan sample (key, pin level, ms stamp) is taken when
//   in_push is high and in_full low. Samples for disabled keys or keys at or
//   beyond NUM_KEYS produce nothing.
//   Result queue: while out_empty is low, out_item holds the oldest event;
//   out_pop takes it. Each sample gives zero, one or two events; the last
//   one carries last_event.
//   Config: cfg_we writes cfg_wdata into register cfg_index. The user must
//   write only while the block is idle; the block itself does not enforce it.
//   Flow: a sample is classified and queued (two entries), then popped and
//   evaluated by the back end; a held key past the long-press time with
//   repeat enabled also passes through the serial repeat divider. The back
//   end takes a new sample only once it is done with the last one.
//   A stalled result side fills the four-entry result queue past two entries;
//   the evaluator then waits, the sample queue fills and in_full rises.
//   Reset: synchronous, clears all key state to released and the registers
//   to their defaults; no clearing pass is needed.
module key_event_detector_unit #(
  parameter int NUM_KEYS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  ked_pkg::in_item_t  in_item,
  output logic               in_full,
  output logic               out_empty,
  output ked_pkg::out_item_t out_item,
  input  logic               out_pop,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import ked_pkg::*;

  cfg_t  cfg_r;
  logic  wq_valid, wq_pop;
  work_t wq_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_high         <= 1'b0;
      cfg_r.debounce_ms         <= 16'd20;
      cfg_r.long_press_ms       <= 16'd1000;
      cfg_r.repeat_interval_ms  <= 16'd100;
      cfg_r.long_press_enable   <= 1'b1;
      cfg_r.double_click_enable <= 1'b1;
      cfg_r.repeat_enable       <= 1'b0;
      cfg_r.key_enable_mask     <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_HIGH: cfg_r.active_high         <= cfg_wdata[0];
        REG_DEBOUNCE:    cfg_r.debounce_ms         <= cfg_wdata;
        REG_LONG_PRESS:  cfg_r.long_press_ms       <= cfg_wdata;
        REG_REPEAT_IVL:  cfg_r.repeat_interval_ms  <= cfg_wdata;
        REG_LONG_EN:     cfg_r.long_press_enable   <= cfg_wdata[0];
        REG_DOUBLE_EN:   cfg_r.double_click_enable <= cfg_wdata[0];
        REG_REPEAT_EN:   cfg_r.repeat_enable       <= cfg_wdata[0];
        REG_KEY_MASK:    cfg_r.key_enable_mask     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  ked_front #(.NUM_KEYS(NUM_KEYS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .wq_valid (wq_valid),
    .wq_item  (wq_item),
    .wq_pop   (wq_pop)
  );

  ked_back #(.NUM_KEYS(NUM_KEYS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .wq_valid  (wq_valid),
    .wq_item   (wq_item),
    .wq_pop    (wq_pop),
    .out_empty (out_empty),
    .out_item  (out_item),
    .out_pop   (out_pop)
  );
endmodule

>>> test/ked_checker.sv
// ked_checker: watches the sample and event queues of the key event detector,
// predicts the events of each accepted sample and compares them. Depends on ked_pkg.
`timescale 1ns / 100ps
module ked_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  ked_pkg::in_item_t  in_item,
  input  logic               in_full,
  input  logic               out_empty,
  input  ked_pkg::out_item_t out_item,
  input  logic               out_pop,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending,
  output int                 event_total
);
  import ked_pkg::*;

  cfg_t        regs;
  logic [1:0]  phase [8];
  logic [31:0] press_at [8];
  logic [31:0] release_at [8];
  logic [15:0] clicks [8];
  logic [31:0] hold_at [8];
  out_item_t   expected_events [$];

  assign pending = expected_events.size();

  // Work out the events of one sample and advance the key's state
  task automatic predict_events(input in_item_t s);
    logic [2:0]  k;
    logic        down;
    logic [31:0] dur, ivl, cnt;
    logic [2:0]  codes [2];
    int          n;
    k = s.key_index;
    n = 0;
    if (regs.key_enable_mask[k]) begin
      down = regs.active_high ? s.pin_level : !s.pin_level;
      dur = s.now_ms - press_at[k];
      case (phase[k])
        PH_RELEASED: begin
          if (down) begin
            phase[k] = PH_DEBOUNCE;
            press_at[k] = s.now_ms;
          end
        end
        PH_DEBOUNCE: begin
          if (!down) begin
            phase[k] = PH_RELEASED;
          end else if (dur >= {16'd0, regs.debounce_ms}) begin
            phase[k] = PH_PRESSED;
            codes[n] = EV_DOWN;
            n = n + 1;
            if (regs.double_click_enable) begin
              if (s.now_ms - release_at[k] < DOUBLE_WINDOW_MS) begin
                clicks[k] = clicks[k] + 16'd1;
                if (clicks[k] == 16'd2) begin
                  codes[n] = EV_DOUBLE;
                  n = n + 1;
                  clicks[k] = '0;
                end
              end else begin
                clicks[k] = 16'd1;
              end
            end
          end
        end
        PH_PRESSED: begin
          if (!down) begin
            phase[k] = PH_DEBOUNCE;
            release_at[k] = s.now_ms;
            codes[0] = EV_UP;
            codes[1] = (dur < {16'd0, regs.long_press_ms}) ? EV_SHORT : EV_LONG_UP;
            n = 2;
          end else begin
            if (regs.long_press_enable && dur >= {16'd0, regs.long_press_ms}) begin
              phase[k] = PH_LONG;
              codes[n] = EV_LONG_START;
              n = n + 1;
            end
            if (regs.repeat_enable && dur > {16'd0, regs.long_press_ms}) begin
              ivl = (regs.repeat_interval_ms == 0) ? 32'd1 : {16'd0, regs.repeat_interval_ms};
              cnt = (dur - {16'd0, regs.long_press_ms}) / ivl;
              if (cnt > {16'd0, clicks[k]}) begin
                codes[n] = EV_REPEAT;
                n = n + 1;
                clicks[k] = cnt[15:0];
              end
            end
          end
        end
        default: begin
          if (!down) begin
            phase[k] = PH_DEBOUNCE;
            release_at[k] = s.now_ms;
            codes[0] = EV_UP;
            codes[1] = EV_LONG_UP;
            n = 2;
          end else if (s.now_ms - hold_at[k] >= HOLD_PERIOD_MS) begin
            codes[0] = EV_HOLD;
            n = 1;
            hold_at[k] = s.now_ms;
          end
        end
      endcase
    end
    for (int i = 0; i < n; i++)
      expected_events.push_back('{event_key: k, event_code: codes[i],
                                  last_event: (i == n - 1)});
  endtask

  // Track register writes and accepted beats on both sides
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      regs <= '{active_high: 1'b0, debounce_ms: 16'd20, long_press_ms: 16'd1000,
                repeat_interval_ms: 16'd100, long_press_enable: 1'b1,
                double_click_enable: 1'b1, repeat_enable: 1'b0, key_enable_mask: 8'h00};
      for (int i = 0; i < 8; i++) begin
        phase[i] = PH_RELEASED;
        press_at[i] = '0;
        release_at[i] = '0;
        clicks[i] = '0;
        hold_at[i] = '0;
      end
      expected_events.delete();
      fail_count <= 0;
      event_total <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ACTIVE_HIGH: regs.active_high <= cfg_wdata[0];
          REG_DEBOUNCE:    regs.debounce_ms <= cfg_wdata;
          REG_LONG_PRESS:  regs.long_press_ms <= cfg_wdata;
          REG_REPEAT_IVL:  regs.repeat_interval_ms <= cfg_wdata;
          REG_LONG_EN:     regs.long_press_enable <= cfg_wdata[0];
          REG_DOUBLE_EN:   regs.double_click_enable <= cfg_wdata[0];
          REG_REPEAT_EN:   regs.repeat_enable <= cfg_wdata[0];
          default:         regs.key_enable_mask <= cfg_wdata[7:0];
        endcase
      end
      if (out_pop && !out_empty) begin
        event_total <= event_total + 1;
        if (expected_events.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected event beat %p", out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_events.pop_front();
          if (want !== out_item) begin
            if (fail_count < 10)
              $display("ERROR: event mismatch exp %p got %p", want, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_push && !in_full)
        predict_events(in_item);
    end
  end
endmodule

>>> test/testbench.sv
// testbench: stimulus and verdict for key_event_detector_unit.
// Depends on ked_pkg, the block and ked_checker.
`timescale 1ns / 100ps
module testbench;
  import ked_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_item_t in_item = '0;
  logic in_full, out_empty;
  out_item_t out_item;
  logic out_pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  int fail_count, pending, event_total;
  int cycles = 0;
  int samples_sent = 0;
  logic [31:0] clock_ms [8];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  key_event_detector_unit DUT (.*);

  ked_checker u_checker (.*);

  // Timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stall before each pop; pop stays up
  // between beats when there is no stall
  always begin
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      out_pop <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    out_pop <= 1'b1;
    @(posedge clk);
    while (out_empty) @(posedge clk);
  end

  // One sample beat after a random gap; push held until accepted and left up
  // so that a following beat with no gap goes straight on
  task automatic send_sample(input logic [2:0] k, input logic lvl, input logic [31:0] t);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= '{key_index: k, pin_level: lvl, now_ms: t};
    @(posedge clk);
    while (in_full) @(posedge clk);
    samples_sent++;
  endtask

  task automatic drain_events();
    in_push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    in_push <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Press/hold/release sequence on one key with random step sizes
  task automatic press_cycle(input logic [2:0] k, input logic ah, input int step_max);
    int steps;
    steps = $urandom_range(2, 10);
    send_sample(k, ah, clock_ms[k]);
    for (int i = 0; i < steps; i++) begin
      clock_ms[k] += $urandom_range(0, step_max);
      send_sample(k, ah, clock_ms[k]);
    end
    clock_ms[k] += $urandom_range(0, 300);
    send_sample(k, !ah, clock_ms[k]);
    if ($urandom_range(0, 2) == 0) begin
      clock_ms[k] += $urandom_range(0, 40);
      send_sample(k, ah, clock_ms[k]);
    end
    clock_ms[k] += $urandom_range(0, 600);
    send_sample(k, !ah, clock_ms[k]);
  endtask

  initial begin
    logic ah;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: disabled keys first, then a click, double click and long press
    send_sample(3'd0, 1'b0, 32'd0);
    write_reg(REG_KEY_MASK, 16'hFFFF);
    send_sample(3'd1, 1'b0, 32'd10);
    send_sample(3'd1, 1'b0, 32'd40);
    send_sample(3'd1, 1'b1, 32'd100);
    send_sample(3'd1, 1'b0, 32'd150);
    send_sample(3'd1, 1'b0, 32'd200);
    send_sample(3'd1, 1'b0, 32'd1300);
    send_sample(3'd1, 1'b0, 32'd1600);
    send_sample(3'd1, 1'b1, 32'd1700);
    send_sample(3'd7, 1'b0, 32'hFFFF_FFF0);
    send_sample(3'd7, 1'b0, 32'h0000_0010);
    send_sample(3'd7, 1'b1, 32'hFFFF_FFFF);
    drain_events();

    // Extremes: zero debounce/long time, zero repeat interval, repeats on
    write_reg(REG_ACTIVE_HIGH, 16'd1);
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_LONG_PRESS, 16'd0);
    write_reg(REG_REPEAT_IVL, 16'd0);
    write_reg(REG_REPEAT_EN, 16'd1);
    write_reg(REG_LONG_EN, 16'd0);
    send_sample(3'd2, 1'b1, 32'd5);
    send_sample(3'd2, 1'b1, 32'd5);
    send_sample(3'd2, 1'b1, 32'd9);
    send_sample(3'd2, 1'b1, 32'd70000);
    send_sample(3'd2, 1'b0, 32'd70001);
    send_sample(3'd2, 1'b1, 32'd70002);
    drain_events();
    write_reg(REG_DEBOUNCE, 16'hFFFF);
    write_reg(REG_LONG_PRESS, 16'hFFFF);
    write_reg(REG_REPEAT_IVL, 16'hFFFF);
    write_reg(REG_DOUBLE_EN, 16'd0);
    send_sample(3'd4, 1'b1, 32'd0);
    send_sample(3'd4, 1'b1, 32'hFFFF_FFFF);
    send_sample(3'd4, 1'b0, 32'hFFFF_FFFF);
    drain_events();

    for (int i = 0; i < 8; i++) clock_ms[i] = $urandom;

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 10; ph++) begin
      drain_events();
      ah = $urandom_range(0, 1);
      write_reg(REG_ACTIVE_HIGH, {15'd0, ah});
      write_reg(REG_DEBOUNCE, (ph == 9) ? 16'hFFFF : 16'($urandom_range(0, 40)));
      write_reg(REG_LONG_PRESS, (ph == 8) ? 16'd0 : 16'($urandom_range(0, 1500)));
      write_reg(REG_REPEAT_IVL, (ph == 7) ? 16'd1 : 16'($urandom_range(0, 300)));
      write_reg(REG_LONG_EN, 16'($urandom_range(0, 1)));
      write_reg(REG_DOUBLE_EN, 16'($urandom_range(0, 1)));
      write_reg(REG_REPEAT_EN, 16'($urandom_range(0, 1)));
      write_reg(REG_KEY_MASK, (ph == 0) ? 16'h00FF : 16'($urandom_range(0, 255)));
      for (int j = 0; j < 12; j++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_sample(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom);
        end else begin
          press_cycle(3'($urandom_range(0, 7)), ah, (j % 3 == 0) ? 60 : 400);
        end
      end
    end

    drain_events();
    $display("Sent %0d scan samples over 10 register settings, %0d events checked.",
             samples_sent, event_total);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> key_event_detector_unit.f
rtl/ked_pkg.sv
rtl/ked_front.sv
rtl/ked_div.sv
rtl/ked_back.sv
rtl/key_event_detector_unit.sv
test/ked_checker.sv
test/testbench.sv
